@@ hw/rtl/lcs_pkg.sv @@
package lcs_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 2048;
    localparam int MIN_SIZE     = 3;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT) + 1;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 12;
    localparam int PIX_IN_W     = 8;
    localparam int PIX_OUT_W    = 10;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 12;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd720;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd576;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // One line-store word: the row just above and the row two above, same column.
    typedef struct packed {
        logic [PIX_IN_W-1:0] above;
        logic [PIX_IN_W-1:0] two_above;
    } line_word_t;

    typedef struct packed {
        logic [PIX_OUT_W-1:0] pixel_out;
        logic                 frame_last;
    } out_word_t;

    // d = 5*centre - (up + down + left + right); clamp and scale to 10 bits.
    function automatic logic [PIX_OUT_W-1:0] sharpen(
        input logic [PIX_IN_W-1:0] centre,
        input logic [PIX_IN_W-1:0] up,
        input logic [PIX_IN_W-1:0] down,
        input logic [PIX_IN_W-1:0] left,
        input logic [PIX_IN_W-1:0] right
    );
        logic signed [12:0] times5;
        logic signed [12:0] ring;
        logic signed [12:0] d;
        logic [PIX_OUT_W-1:0] res;
        times5 = 13'sd5 * $signed({5'd0, centre});
        ring   = $signed({5'd0, up}) + $signed({5'd0, down})
               + $signed({5'd0, left}) + $signed({5'd0, right});
        d      = times5 - ring;
        if (d < 13'sd0) begin
            res = '0;
        end else if (d >= 13'sd256) begin
            res = '1;
        end else begin
            res = {d[7:0], 2'b10};
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/lcs_line_store.sv @@
module lcs_line_store (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [lcs_pkg::COL_W-1:0]    wr_addr,
    input  lcs_pkg::line_word_t          wr_data,
    input  logic [lcs_pkg::COL_W-1:0]    rd_addr_a,
    input  logic [lcs_pkg::COL_W-1:0]    rd_addr_b,
    output lcs_pkg::line_word_t          rd_data_a,
    output lcs_pkg::line_word_t          rd_data_b
);

    lcs_pkg::line_word_t mem [lcs_pkg::MAX_WIDTH];
    lcs_pkg::line_word_t rd_a_reg;
    lcs_pkg::line_word_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read ports run every cycle; read data is registered and shows up in the next cycle.
    always_ff @(posedge aclk) begin
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

@@ hw/rtl/lcs_out_skid.sv @@
module lcs_out_skid (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    input  lcs_pkg::out_word_t   push_data,
    output logic                 push_ready,
    output logic                 m_valid,
    output lcs_pkg::out_word_t   m_data,
    input  logic                 m_ready
);

    logic               out_valid_reg;
    logic               skid_valid_reg;
    lcs_pkg::out_word_t out_data_reg;
    lcs_pkg::out_word_t skid_data_reg;
    logic               take;

    assign take       = out_valid_reg & m_ready;
    assign push_ready = ~skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // drain the skid word into the output slot
            if (take) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (push_valid) begin
            if (!out_valid_reg || take) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push_valid) begin
            if (!out_valid_reg || take) begin
                out_data_reg <= push_data;
            end else begin
                skid_data_reg <= push_data;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ hw/rtl/luma_cross_sharpen_10bit_core.sv @@
// Cross-shaped 3x3 sharpener: 8-bit luma in, 10-bit sharpened luma out.
// Input stream (s_): one word per pixel in raster order. s_tuser is the
// opcode: pixel word or flush word. Output stream (m_): one word per output
// pixel, m_tlast high on the final pixel of a frame.
// While input row r arrives, output row r-1 leaves; the first input row gives
// no output. After the last input row, send flush words: each one emits a
// pixel of the final (all zero) output row. Flush words sent earlier are
// dropped. Frame border pixels come out as zero.
// Throughput: one word per cycle while s_tready is high; the two line stores
// share one dual-read memory that is prefetched from the next column count,
// so every neighbor is ready when the pixel arrives.
// Receiver stall: a two-entry output stage (register plus skid) absorbs one
// extra word, then s_tready drops until m_tready returns.
// Reset: counters go to the frame start and the size registers to 720x576.
// The line stores are not cleared; each entry is written before it is read.
// A size write through cfg_ restarts the frame; write only while idle.
module luma_cross_sharpen_10bit_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [lcs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lcs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] pixel_in
    input  logic                             s_tuser,   // [0] opcode
    // output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,   // [9:0] pixel_out, [15:10] zero
    output logic                             m_tlast    // frame_last
);

    logic [lcs_pkg::WIDTH_REG_W-1:0]  frame_width_reg;
    logic [lcs_pkg::HEIGHT_REG_W-1:0] frame_height_reg;

    logic [lcs_pkg::COL_W-1:0] col_reg, col_next;
    logic [lcs_pkg::ROW_W-1:0] row_reg, row_next;
    logic [lcs_pkg::PIX_IN_W-1:0] left_reg, left_next;

    logic [lcs_pkg::WIDTH_REG_W-1:0]  eff_width;
    logic [lcs_pkg::WIDTH_REG_W-1:0]  width_m1_full;
    logic [lcs_pkg::COL_W-1:0]        width_m1;
    logic [lcs_pkg::ROW_W-1:0]        eff_height;

    logic accept;
    logic flush_phase;
    logic last_col;
    logic is_pixel;

    lcs_pkg::line_word_t cur_word, next_word, wr_word;
    logic                 mem_wr_en;

    logic                 push_valid;
    logic                 push_ready;
    lcs_pkg::out_word_t   push_data;
    lcs_pkg::out_word_t   out_data;
    logic [lcs_pkg::PIX_OUT_W-1:0] sharp_val;

    // clamp the size registers to the supported range
    always_comb begin
        if (frame_width_reg < lcs_pkg::WIDTH_REG_W'(lcs_pkg::MIN_SIZE)) begin
            eff_width = lcs_pkg::WIDTH_REG_W'(lcs_pkg::MIN_SIZE);
        end else if (frame_width_reg > lcs_pkg::WIDTH_REG_W'(lcs_pkg::MAX_WIDTH)) begin
            eff_width = lcs_pkg::WIDTH_REG_W'(lcs_pkg::MAX_WIDTH);
        end else begin
            eff_width = frame_width_reg;
        end
        if (frame_height_reg < lcs_pkg::HEIGHT_REG_W'(lcs_pkg::MIN_SIZE)) begin
            eff_height = lcs_pkg::ROW_W'(lcs_pkg::MIN_SIZE);
        end else if (frame_height_reg > lcs_pkg::HEIGHT_REG_W'(lcs_pkg::MAX_HEIGHT)) begin
            eff_height = lcs_pkg::ROW_W'(lcs_pkg::MAX_HEIGHT);
        end else begin
            eff_height = lcs_pkg::ROW_W'(frame_height_reg);
        end
    end

    assign width_m1_full = eff_width - lcs_pkg::WIDTH_REG_W'(1);
    assign width_m1      = width_m1_full[lcs_pkg::COL_W-1:0];

    assign s_tready    = push_ready;
    assign accept      = s_tvalid & s_tready;
    assign flush_phase = (row_reg == eff_height);
    assign last_col    = (col_reg == width_m1);
    assign is_pixel    = (s_tuser == lcs_pkg::OP_PIXEL);

    // size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= lcs_pkg::WIDTH_RESET;
            frame_height_reg <= lcs_pkg::HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                lcs_pkg::REG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_wdata[lcs_pkg::WIDTH_REG_W-1:0];
                end
                lcs_pkg::REG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_wdata[lcs_pkg::HEIGHT_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // position counters: clear on a size write; otherwise advance on every pixel word and on every flush-phase word
    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (cfg_wr_en) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (flush_phase) begin
                if (last_col) begin
                    col_next = '0;
                    row_next = '0;
                end else begin
                    col_next = col_reg + lcs_pkg::COL_W'(1);
                end
            end else if (is_pixel) begin
                left_next = cur_word.above;
                if (last_col) begin
                    col_next = '0;
                    row_next = row_reg + lcs_pkg::ROW_W'(1);
                end else begin
                    col_next = col_reg + lcs_pkg::COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // previous-row pixel one column left; meaningless at column zero
    always_ff @(posedge aclk) begin
        left_reg <= left_next;
    end

    // shift the column down one row: old above becomes two above
    assign mem_wr_en         = accept & ~flush_phase & is_pixel & ~cfg_wr_en;
    assign wr_word.above     = s_tdata;
    assign wr_word.two_above = cur_word.above;

    // prefetch the words at the next column and the one after it
    lcs_line_store u_line_store (
        .aclk      (aclk),
        .wr_en     (mem_wr_en),
        .wr_addr   (col_reg),
        .wr_data   (wr_word),
        .rd_addr_a (col_next),
        .rd_addr_b (col_next + lcs_pkg::COL_W'(1)),
        .rd_data_a (cur_word),
        .rd_data_b (next_word)
    );

    assign sharp_val = lcs_pkg::sharpen(cur_word.above, cur_word.two_above, s_tdata,
                                        left_reg, next_word.above);

    // build the result word
    always_comb begin
        push_valid           = 1'b0;
        push_data.pixel_out  = '0;
        push_data.frame_last = 1'b0;
        if (accept && !cfg_wr_en) begin
            if (flush_phase) begin
                push_valid           = 1'b1;
                push_data.frame_last = last_col;
            end else if (is_pixel && row_reg != '0) begin
                push_valid = 1'b1;
                if (row_reg != lcs_pkg::ROW_W'(1) && col_reg != '0 && !last_col) begin
                    push_data.pixel_out = sharp_val;
                end
            end
        end
    end

    lcs_out_skid u_out_skid (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .m_valid    (m_tvalid),
        .m_data     (out_data),
        .m_ready    (m_tready)
    );

    assign m_tdata = {6'd0, out_data.pixel_out};
    assign m_tlast = out_data.frame_last;

endmodule
